FILE: src/mbsd_pkg.sv
// Shared types, event codes and lookup functions for the MIDI byte stream decoder.
`timescale 1ns / 1ps

package mbsd_pkg;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 7;
    localparam int CHAN_W = 4;
    localparam int KIND_W = 5;
    localparam int RUN_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        EV_NOTE_OFF   = 5'd0,
        EV_NOTE_ON    = 5'd1,
        EV_POLY_PRESS = 5'd2,
        EV_CTRL       = 5'd3,
        EV_PROGRAM    = 5'd4,
        EV_CHAN_PRESS = 5'd5,
        EV_PITCHWHEEL = 5'd6,
        EV_SYSEX      = 5'd7,
        EV_EOX        = 5'd8,
        EV_TIMECODE   = 5'd9,
        EV_SONGPOS    = 5'd10,
        EV_SONGSEL    = 5'd11,
        EV_TUNE       = 5'd12,
        EV_CLOCK      = 5'd13,
        EV_START      = 5'd14,
        EV_CONTINUE   = 5'd15,
        EV_STOP       = 5'd16,
        EV_SENSING    = 5'd17,
        EV_RESET      = 5'd18,
        EV_UNDEF      = 5'd19
    } event_kind_t;

    // Running-status message kinds (status byte bits 6:4)
    localparam logic [RUN_W-1:0] RUN_PROGRAM    = 3'd4;
    localparam logic [RUN_W-1:0] RUN_CHAN_PRESS = 3'd5;
    localparam logic [RUN_W-1:0] RUN_NONE       = 3'd7;

    // System-common low nibble codes (bit 3 clear)
    localparam logic [2:0] SC_SYSEX    = 3'd0;
    localparam logic [2:0] SC_TIMECODE = 3'd1;
    localparam logic [2:0] SC_SONGPOS  = 3'd2;
    localparam logic [2:0] SC_SONGSEL  = 3'd3;
    localparam logic [2:0] SC_TUNE     = 3'd6;
    localparam logic [2:0] SC_EOX      = 3'd7;

    typedef enum logic [1:0] {
        SYS_SYSEX    = 2'd0,
        SYS_TIMECODE = 2'd1,
        SYS_SONGPOS  = 2'd2,
        SYS_SONGSEL  = 2'd3
    } sys_kind_t;

    typedef struct packed {
        logic [RUN_W-1:0]  running_kind;
        logic              running_valid;
        logic [CHAN_W-1:0] channel_held;
        logic              awaiting_first_data;
        logic [DATA_W-1:0] held_channel_data;
        logic              sys_common_active;
        logic              sys_first_pending;
        sys_kind_t         sys_kind;
        logic [DATA_W-1:0] held_sys_data;
    } parse_state_t;

    typedef struct packed {
        event_kind_t       kind;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
    } event_t;

    // Decoder to top: one event plus its strobe
    typedef struct packed {
        logic   hit;
        event_t evt;
    } decode_out_t;

    function automatic event_kind_t realtime_kind(input logic [2:0] code);
        event_kind_t k;
        unique case (code)
            3'd0:    k = EV_CLOCK;
            3'd2:    k = EV_START;
            3'd3:    k = EV_CONTINUE;
            3'd4:    k = EV_STOP;
            3'd6:    k = EV_SENSING;
            3'd7:    k = EV_RESET;
            default: k = EV_UNDEF;
        endcase
        return k;
    endfunction

endpackage

FILE: src/mbsd_parser.sv
// Parse state registers and combinational byte decode.
`timescale 1ns / 1ps

module mbsd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mbsd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          advance,
    output mbsd_pkg::decode_out_t         dec
);
    import mbsd_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    logic [DATA_W-1:0] d;

    assign d = rx_byte[DATA_W-1:0];

    always_comb
    begin
        st_next = st_reg;
        dec     = '0;
        if (rx_byte[7])
        begin
            if (rx_byte[7:4] == 4'hF)
            begin
                if (rx_byte[3])
                begin
                    // real-time: emit, state untouched
                    dec.hit      = 1'b1;
                    dec.evt.kind = realtime_kind(rx_byte[2:0]);
                end
                else
                begin
                    st_next.running_valid = 1'b0;
                    unique case (rx_byte[2:0])
                        SC_SYSEX, SC_TIMECODE, SC_SONGPOS, SC_SONGSEL:
                        begin
                            st_next.sys_kind          = sys_kind_t'(rx_byte[1:0]);
                            st_next.sys_common_active = 1'b1;
                            st_next.sys_first_pending = 1'b1;
                        end
                        SC_TUNE:
                        begin
                            st_next.sys_common_active = 1'b0;
                            dec.hit      = 1'b1;
                            dec.evt.kind = EV_TUNE;
                        end
                        SC_EOX:
                        begin
                            st_next.sys_common_active = 1'b0;
                            dec.hit      = 1'b1;
                            dec.evt.kind = EV_EOX;
                        end
                        default:
                        begin
                            st_next.sys_common_active = 1'b0;
                            dec.hit      = 1'b1;
                            dec.evt.kind = EV_UNDEF;
                        end
                    endcase
                end
            end
            else
            begin
                // channel status: new running status
                st_next.sys_common_active   = 1'b0;
                st_next.running_kind        = rx_byte[6:4];
                st_next.channel_held        = rx_byte[3:0];
                st_next.awaiting_first_data = 1'b1;
                st_next.running_valid       = 1'b1;
            end
        end
        else if (st_reg.sys_common_active)
        begin
            if (st_reg.sys_first_pending)
            begin
                unique case (st_reg.sys_kind)
                    SYS_SYSEX:
                    begin
                        dec.hit            = 1'b1;
                        dec.evt.kind       = EV_SYSEX;
                        dec.evt.first_data = d;
                    end
                    SYS_TIMECODE:
                    begin
                        st_next.sys_common_active = 1'b0;
                        dec.hit            = 1'b1;
                        dec.evt.kind       = EV_TIMECODE;
                        dec.evt.first_data = d;
                    end
                    SYS_SONGPOS:
                    begin
                        st_next.held_sys_data     = d;
                        st_next.sys_first_pending = 1'b0;
                    end
                    SYS_SONGSEL:
                    begin
                        st_next.sys_common_active = 1'b0;
                        dec.hit            = 1'b1;
                        dec.evt.kind       = EV_SONGSEL;
                        dec.evt.first_data = d;
                    end
                    default:
                    begin
                        st_next.sys_common_active = 1'b0;
                    end
                endcase
            end
            else
            begin
                st_next.sys_common_active = 1'b0;
                if (st_reg.sys_kind == SYS_SONGPOS)
                begin
                    dec.hit             = 1'b1;
                    dec.evt.kind        = EV_SONGPOS;
                    dec.evt.first_data  = st_reg.held_sys_data;
                    dec.evt.second_data = d;
                end
            end
        end
        else if (st_reg.running_valid)
        begin
            if (st_reg.awaiting_first_data)
            begin
                st_next.held_channel_data = d;
                if (st_reg.running_kind == RUN_PROGRAM ||
                    st_reg.running_kind == RUN_CHAN_PRESS)
                begin
                    dec.hit            = 1'b1;
                    dec.evt.kind       = event_kind_t'({2'b00, st_reg.running_kind});
                    dec.evt.channel    = st_reg.channel_held;
                    dec.evt.first_data = d;
                end
                else
                begin
                    st_next.awaiting_first_data = 1'b0;
                end
            end
            else
            begin
                st_next.awaiting_first_data = 1'b1;
                if (st_reg.running_kind != RUN_NONE)
                begin
                    dec.hit             = 1'b1;
                    dec.evt.kind        = event_kind_t'({2'b00, st_reg.running_kind});
                    dec.evt.channel     = st_reg.channel_held;
                    dec.evt.first_data  = st_reg.held_channel_data;
                    dec.evt.second_data = d;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: src/mbsd_out_reg.sv
// Result register with valid/stall handshake.
`timescale 1ns / 1ps

module mbsd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  mbsd_pkg::event_t evt,
    input  logic             out_stall,
    output logic             free,
    output logic             out_valid,
    output mbsd_pkg::event_t out_evt
);
    import mbsd_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t evt_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_evt   = evt_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            evt_reg <= evt;
    end

endmodule

FILE: src/midi_byte_stream_decoder.sv
// Top level of the MIDI byte stream decoder: input register, parser, result register.
`timescale 1ns / 1ps

// MIDI byte stream decoder. Feed one received byte per item on rx_byte; the block
// returns at most one decoded event per byte, in byte order. Running status is kept
// for channel messages: two-byte messages (note off/on, poly pressure, control,
// pitch wheel) come out on every second data byte, program change and channel
// pressure on every data byte. Time code, song select and song position collect
// their data bytes; each sysex data byte is passed through as a sysex event.
// Real-time bytes emit immediately and never disturb the parse. Tune request, EOX
// and undefined system-common bytes emit and end system-common mode; data bytes
// seen before any status byte are dropped silently. Timing: one byte per cycle
// sustained while in_stall is low. A byte waits in the input register, where the
// parser decodes it against the running state, and its event is loaded into the
// result register as the byte leaves; it is held on the outputs until taken. The
// result register frees in the same cycle it is taken, so in_stall only rises
// when an event is held by out_stall and the byte in the input register also
// emits.
module midi_byte_stream_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mbsd_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mbsd_pkg::KIND_W-1:0]         event_kind,
    output logic [mbsd_pkg::CHAN_W-1:0]         channel,
    output logic [mbsd_pkg::DATA_W-1:0]         first_data,
    output logic [mbsd_pkg::DATA_W-1:0]         second_data
);
    import mbsd_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;

    decode_out_t dec;
    event_t      out_evt;
    logic        out_free;
    logic        s1_advance;
    logic        in_accept;

    // Byte leaves the input register when it emits nothing or the result slot is free
    assign s1_advance = s1_valid_reg && (!dec.hit || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_byte_reg <= rx_byte;
    end

    mbsd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (s1_byte_reg),
        .advance (s1_advance),
        .dec     (dec)
    );

    mbsd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_advance && dec.hit),
        .evt       (dec.evt),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .out_evt   (out_evt)
    );

    assign event_kind  = out_evt.kind;
    assign channel     = out_evt.channel;
    assign first_data  = out_evt.first_data;
    assign second_data = out_evt.second_data;

    // Input only stalls behind a held event with another event waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && dec.hit && out_valid && out_stall))
        else $error("input stalled without a blocked event");

    // Only channel voice events carry a channel number
    a_channel_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && channel != '0) |-> (event_kind <= EV_PITCHWHEEL))
        else $error("channel set on a non-channel event");

    // Second data byte only on two-byte channel messages and song position
    a_second_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && second_data != '0) |->
            (event_kind == EV_NOTE_OFF || event_kind == EV_NOTE_ON ||
             event_kind == EV_POLY_PRESS || event_kind == EV_CTRL ||
             event_kind == EV_PITCHWHEEL || event_kind == EV_SONGPOS))
        else $error("second data byte on a one-byte event");

endmodule

FILE: tb/midi_byte_stream_decoder_tb.sv
// Self-checking testbench for the MIDI byte stream decoder: event predictor, byte driver, event monitor.
`timescale 1ns / 1ps

module midi_byte_stream_decoder_tb;

    import mbsd_pkg::*;

    // MIDI status bytes (channel kinds carry channel 0 in the low nibble)
    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
    localparam logic [7:0] ST_CTRL       = 8'hB0;
    localparam logic [7:0] ST_PROGRAM    = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_PITCHWHEEL = 8'hE0;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_TIMECODE   = 8'hF1;
    localparam logic [7:0] ST_SONGPOS    = 8'hF2;
    localparam logic [7:0] ST_SONGSEL    = 8'hF3;
    localparam logic [7:0] ST_UNDEF_F4   = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5   = 8'hF5;
    localparam logic [7:0] ST_TUNE       = 8'hF6;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_UNDEF_F9   = 8'hF9;
    localparam logic [7:0] ST_START      = 8'hFA;
    localparam logic [7:0] ST_CONTINUE   = 8'hFB;
    localparam logic [7:0] ST_STOP       = 8'hFC;
    localparam logic [7:0] ST_UNDEF_FD   = 8'hFD;
    localparam logic [7:0] ST_SENSING    = 8'hFE;
    localparam logic [7:0] ST_SYS_RESET  = 8'hFF;

    localparam int ITEM_TARGET  = 1200;
    localparam int QUIET_FROM   = 1000;   // no idling on either side past this item count
    localparam int HOLD_CYCLES  = 60;     // long receiver hold-off
    localparam int TAIL_CYCLES  = 10;     // generous tail
    localparam int CYCLE_LIMIT  = 200000;

    // Predicts the decoder's events from the accepted bytes and checks them in order.
    class event_predictor;
        logic [RUN_W-1:0]  run_kind;
        logic              run_valid;
        logic [CHAN_W-1:0] run_chan;
        logic              await_first;
        logic [DATA_W-1:0] held_data;
        logic              sys_active;
        logic              sys_first;
        logic [2:0]        sys_code;
        logic [DATA_W-1:0] held_sys_data;
        event_t            pending_events[$];
        int                errors;

        function new();
            run_kind      = '0;
            run_valid     = 1'b0;
            run_chan      = '0;
            await_first   = 1'b0;
            held_data     = '0;
            sys_active    = 1'b0;
            sys_first     = 1'b0;
            sys_code      = '0;
            held_sys_data = '0;
            errors        = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        // Advance the parse by one accepted byte; queue the event it causes, if any.
        function void accept_byte(logic [7:0] b);
            event_t            e;
            bit                hit;
            logic [DATA_W-1:0] d;
            e   = '0;
            hit = 0;
            d   = b[6:0];
            if (b[7]) begin
                if (b[7:4] == 4'hF) begin
                    if (b[3]) begin
                        // real-time: emit, parse state untouched
                        hit = 1;
                        case (b)
                            ST_CLOCK:     e.kind = EV_CLOCK;
                            ST_START:     e.kind = EV_START;
                            ST_CONTINUE:  e.kind = EV_CONTINUE;
                            ST_STOP:      e.kind = EV_STOP;
                            ST_SENSING:   e.kind = EV_SENSING;
                            ST_SYS_RESET: e.kind = EV_RESET;
                            default:      e.kind = EV_UNDEF;
                        endcase
                    end
                    else begin
                        run_valid = 1'b0;
                        case (b[2:0])
                            SC_SYSEX, SC_TIMECODE, SC_SONGPOS, SC_SONGSEL:
                            begin
                                sys_code   = b[2:0];
                                sys_active = 1'b1;
                                sys_first  = 1'b1;
                            end
                            SC_TUNE:
                            begin
                                sys_active = 1'b0;
                                hit        = 1;
                                e.kind     = EV_TUNE;
                            end
                            SC_EOX:
                            begin
                                sys_active = 1'b0;
                                hit        = 1;
                                e.kind     = EV_EOX;
                            end
                            default:
                            begin
                                sys_active = 1'b0;
                                hit        = 1;
                                e.kind     = EV_UNDEF;
                            end
                        endcase
                    end
                end
                else begin
                    sys_active  = 1'b0;
                    run_kind    = b[6:4];
                    run_chan    = b[3:0];
                    await_first = 1'b1;
                    run_valid   = 1'b1;
                end
            end
            else if (sys_active) begin
                if (sys_first) begin
                    case (sys_code)
                        SC_SYSEX:
                        begin
                            hit          = 1;
                            e.kind       = EV_SYSEX;
                            e.first_data = d;
                        end
                        SC_TIMECODE:
                        begin
                            sys_active   = 1'b0;
                            hit          = 1;
                            e.kind       = EV_TIMECODE;
                            e.first_data = d;
                        end
                        SC_SONGPOS:
                        begin
                            held_sys_data = d;
                            sys_first     = 1'b0;
                        end
                        SC_SONGSEL:
                        begin
                            sys_active   = 1'b0;
                            hit          = 1;
                            e.kind       = EV_SONGSEL;
                            e.first_data = d;
                        end
                        default:
                            sys_active = 1'b0;
                    endcase
                end
                else begin
                    sys_active = 1'b0;
                    if (sys_code == SC_SONGPOS) begin
                        hit           = 1;
                        e.kind        = EV_SONGPOS;
                        e.first_data  = held_sys_data;
                        e.second_data = d;
                    end
                end
            end
            else if (run_valid) begin
                if (await_first) begin
                    held_data = d;
                    if (run_kind == RUN_PROGRAM || run_kind == RUN_CHAN_PRESS) begin
                        hit          = 1;
                        e.kind       = event_kind_t'(KIND_W'(run_kind));
                        e.channel    = run_chan;
                        e.first_data = d;
                    end
                    else begin
                        await_first = 1'b0;
                    end
                end
                else begin
                    await_first = 1'b1;
                    if (run_kind != RUN_NONE) begin
                        hit           = 1;
                        e.kind        = event_kind_t'(KIND_W'(run_kind));
                        e.channel     = run_chan;
                        e.first_data  = held_data;
                        e.second_data = d;
                    end
                end
            end
            if (hit)
                pending_events.push_back(e);
        endfunction

        function void check_event(logic [KIND_W-1:0] k, logic [CHAN_W-1:0] ch,
                                  logic [DATA_W-1:0] d1, logic [DATA_W-1:0] d2);
            event_t e;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event kind=%0d ch=%0d d1=%0d d2=%0d",
                         $time, k, ch, d1, d2);
                return;
            end
            e = pending_events.pop_front();
            if (e.kind !== k) begin
                errors++;
                $display("%0t: event_kind expected %0d actual %0d", $time, e.kind, k);
            end
            if (e.channel !== ch) begin
                errors++;
                $display("%0t: channel expected %0d actual %0d", $time, e.channel, ch);
            end
            if (e.first_data !== d1) begin
                errors++;
                $display("%0t: first_data expected %0d actual %0d", $time, e.first_data, d1);
            end
            if (e.second_data !== d2) begin
                errors++;
                $display("%0t: second_data expected %0d actual %0d", $time, e.second_data, d2);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   event_kind;
    logic [CHAN_W-1:0]   channel;
    logic [DATA_W-1:0]   first_data;
    logic [DATA_W-1:0]   second_data;

    event_predictor predictor;
    int             sent_items;
    int             cycles;
    bit             quiet;        // suppresses idling in the final stretch
    bit             hold_req;     // main asks the receiver for a long hold-off
    int             hold_left;
    int             burst_left;

    midi_byte_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .channel     (channel),
        .first_data  (first_data),
        .second_data (second_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stall bursts, plus the long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end
        else if (burst_left > 0) begin
            out_stall = 1'b1;
            burst_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_stall  = 1'b1;
            burst_left = $urandom_range(1, 3) - 1;
        end
        else begin
            out_stall = 1'b0;
        end
    end

    // Event monitor and cycle watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("midi_byte_stream_decoder_tb: done, errors");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall) begin
            predictor.check_event(event_kind, channel, first_data, second_data);
        end
    end

    // Offer one item; returns at the falling edge after it was accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap      = $urandom_range(1, 3);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predictor.accept_byte(b);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] any_realtime();
        return ST_CLOCK | 8'($urandom_range(0, 7));
    endfunction

    // Data byte, now and then preceded by a real-time byte cutting in.
    task automatic send_data(input logic [6:0] d);
        if ($urandom_range(0, 19) == 0)
            send_byte(any_realtime());
        send_byte({1'b0, d});
    endtask

    // Sender pause: hold off until every expected event has come out.
    task automatic drain();
        in_valid = 1'b0;
        while (predictor.pending() > 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Receiver stops for a long stretch while real-time items keep coming,
    // so the result and input registers fill and in_stall rises.
    task automatic backpressure_burst();
        hold_req = 1;
        repeat (24)
            send_byte(any_realtime());
    endtask

    // One random message: mostly well formed, some broken sequences and noise.
    task automatic send_message();
        int         pick;
        int         n;
        logic [2:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            k = 3'($urandom_range(0, 6));
            // sometimes lean on running status left from before
            if ($urandom_range(0, 3) != 0)
                send_byte(ST_NOTE_OFF | {1'b0, k, 4'($urandom_range(0, 15))});
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_data(7'($urandom_range(0, 127)));
                if (k != RUN_PROGRAM && k != RUN_CHAN_PRESS)
                    send_data(7'($urandom_range(0, 127)));
            end
            // odd trailing data byte half-completes a two-byte message
            if ($urandom_range(0, 9) == 0)
                send_data(7'($urandom_range(0, 127)));
        end
        else if (pick < 70) begin
            send_byte(ST_SYSEX);
            n = $urandom_range(0, 6);
            repeat (n)
                send_data(7'($urandom_range(0, 127)));
            case ($urandom_range(0, 4))
                0:       send_byte(ST_NOTE_ON | 8'($urandom_range(0, 15)));
                1:       send_byte(ST_SYSEX);
                default: send_byte(ST_EOX);
            endcase
        end
        else if (pick < 80) begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_byte(ST_TIMECODE);
                    send_data(7'($urandom_range(0, 127)));
                end
                1:
                begin
                    send_byte(ST_SONGPOS);
                    send_data(7'($urandom_range(0, 127)));
                    if ($urandom_range(0, 4) != 0)
                        send_data(7'($urandom_range(0, 127)));
                end
                default:
                begin
                    send_byte(ST_SONGSEL);
                    send_data(7'($urandom_range(0, 127)));
                end
            endcase
            // stray data after the message: ignored, or completes a song position left one byte short
            if ($urandom_range(0, 7) == 0)
                send_data(7'($urandom_range(0, 127)));
        end
        else if (pick < 88) begin
            send_byte(any_realtime());
        end
        else if (pick < 94) begin
            case ($urandom_range(0, 3))
                0:       send_byte(ST_TUNE);
                1:       send_byte(ST_UNDEF_F4);
                2:       send_byte(ST_UNDEF_F5);
                default: send_byte(ST_EOX);
            endcase
        end
        else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        logic [7:0] directed[$];
        bit         squeezed_early;
        bit         squeezed_late;
        bit         paused_mid;

        predictor  = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        out_stall  = 1'b0;
        sent_items = 0;
        cycles     = 0;
        quiet      = 0;
        hold_req   = 0;
        hold_left  = 0;
        burst_left = 0;
        squeezed_early = 0;
        squeezed_late  = 0;
        paused_mid     = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: data before status, running status across a real-time
        // byte, field extremes, sysex pass-through, every system-common
        // message, the undefined bytes, and a channel status ending sysex.
        directed = '{
            8'h00, 8'h7F,
            ST_NOTE_ON | 8'h0F, 8'h3C, ST_CLOCK, 8'h7F, 8'h00, 8'h40,
            ST_PROGRAM, 8'h05, 8'h7F,
            ST_SYSEX, 8'h7E, 8'h01, ST_EOX,
            ST_TIMECODE, 8'h55,
            ST_SONGPOS, 8'h12, 8'h34,
            ST_SONGSEL, 8'h09,
            ST_TUNE, ST_UNDEF_F4, ST_UNDEF_F5,
            ST_UNDEF_F9, ST_UNDEF_FD, ST_SYS_RESET,
            ST_SYSEX, 8'h2A, ST_PITCHWHEEL | 8'h07, 8'h00, 8'h7F
        };
        foreach (directed[i])
            send_byte(directed[i]);
        drain();

        while (sent_items < ITEM_TARGET) begin
            if (!squeezed_early && sent_items >= 300) begin
                squeezed_early = 1;
                backpressure_burst();
            end
            if (!paused_mid && sent_items >= 600) begin
                paused_mid = 1;
                drain();
            end
            if (!squeezed_late && sent_items >= 850) begin
                squeezed_late = 1;
                backpressure_burst();
            end
            if (sent_items >= QUIET_FROM)
                quiet = 1;
            send_message();
        end
        in_valid = 1'b0;

        // Wait for the last events, then let the pipeline settle.
        while (predictor.pending() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predictor.errors == 0)
            $display("midi_byte_stream_decoder_tb: done, clean");
        else
            $display("midi_byte_stream_decoder_tb: done, errors");
        $finish;
    end

endmodule
